### design/iq_pkg.sv
// Shared types and constants for the indexed queue.
`default_nettype none

package iq_pkg;

    localparam int unsigned DEFAULT_DEPTH = 16;
    localparam int unsigned DATA_W        = 32;

    // Request kinds as they arrive on the input channel.
    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_INSERT = 2'd2,
        MODE_REMOVE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Action broadcast to every cell for one cycle.
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2
    } t_act;

    localparam logic [DATA_W-1:0] FAIL_VALUE = '1;

endpackage : iq_pkg

`default_nettype wire

### design/iq_cell.sv
// One storage cell of the queue chain: holds an entry and shifts with its neighbors.
`default_nettype none

module iq_cell
    import iq_pkg::*;
#(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CNT_W = 5,
    parameter bit          LAST  = 1'b0
) (
    input  wire logic              i_clk,
    input  wire t_act              i_act,
    input  wire logic [CNT_W-1:0]  i_pos,
    input  wire logic [DATA_W-1:0] i_value,
    input  wire logic [DATA_W-1:0] i_left,
    input  wire logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0]      o_data,
    output logic [DATA_W-1:0]      o_sel_data
);

    localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              hit;

    assign hit = (MyIdx == i_pos);

    // An insert opens a gap at the position by moving higher cells one place up;
    // a remove closes it by pulling the higher cells one place down.
    always_comb begin
        n_data = r_data;
        unique case (i_act)
            ACT_INSERT: begin
                if (hit) begin
                    n_data = i_value;
                end else if (MyIdx > i_pos) begin
                    n_data = i_left;
                end
            end
            ACT_REMOVE: begin
                if (!LAST && MyIdx >= i_pos) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data     = r_data;
    assign o_sel_data = hit ? r_data : '0;

endmodule : iq_cell

`default_nettype wire

### design/indexed_queue_top.sv
// Top level of the indexed queue: request decode, cell chain and result register.
//
// Input channel: i_in_valid with i_mode, i_value_in and i_position; the block
// drives o_in_stall. A transfer happens on a rising edge with valid high and
// stall low. Modes are push at tail, pop from head, insert at a position and
// remove from a position; position 0 is the head.
// Output channel: o_out_valid with o_value_out, o_status and o_occupancy; the
// receiver drives i_out_stall. Every request gives exactly one result.
// The result is visible the cycle after the input transfer. Throughput is one
// request per cycle unless a result waits under i_out_stall, because every
// cell of the chain moves to its neighbor's value in the same cycle and the
// removed value is picked from the cell outputs before they shift.
// While a result waits under i_out_stall, o_in_stall is high and the queue
// contents hold; the result is kept until it is taken.
// Reset empties the queue and drops any pending result. Cell contents are not
// cleared; only entries below the occupancy are ever read.
`default_nettype none

module indexed_queue_top
    import iq_pkg::*;
#(
    parameter int unsigned DEPTH = DEFAULT_DEPTH,
    localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [1:0]               i_mode,
    input  wire logic signed [DATA_W-1:0] i_value_in,
    input  wire logic [CntW-1:0]          i_position,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [DATA_W-1:0]      o_value_out,
    output logic [1:0]                    o_status,
    output logic [CntW-1:0]               o_occupancy
);

    localparam logic [CntW-1:0] Full = CntW'(DEPTH);

    logic [CntW-1:0]   r_count;
    logic [CntW-1:0]   n_count;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;
    t_status           r_status;
    t_status           n_status;

    logic              accept;
    t_mode             mode;
    t_act              act;
    logic [CntW-1:0]   cell_pos;
    logic [DATA_W-1:0] picked;

    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] cell_sel  [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign mode       = t_mode'(i_mode);

    // Decode the request into one cell action and its position.
    always_comb begin
        act      = ACT_NONE;
        cell_pos = i_position;
        n_status = ST_OK;
        n_value  = '0;
        n_count  = r_count;
        unique case (mode)
            MODE_PUSH: begin
                cell_pos = r_count;
                if (r_count == Full) begin
                    n_status = ST_FULL;
                end else begin
                    act     = ACT_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            MODE_POP: begin
                cell_pos = '0;
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    act     = ACT_REMOVE;
                    n_value = picked;
                    n_count = r_count - 1'b1;
                end
            end
            MODE_INSERT: begin
                priority if (r_count == Full) begin
                    n_status = ST_FULL;
                end else if (i_position > r_count) begin
                    n_status = ST_EMPTY;
                end else begin
                    act     = ACT_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (i_position >= r_count) begin
                    n_status = ST_EMPTY;
                    n_value  = FAIL_VALUE;
                end else begin
                    act     = ACT_REMOVE;
                    n_value = picked;
                    n_count = r_count - 1'b1;
                end
            end
            default: act = ACT_NONE;
        endcase
        if (!accept) begin
            act = ACT_NONE;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [DATA_W-1:0] left_data;
            logic [DATA_W-1:0] right_data;
            if (g == 0) begin : g_head
                assign left_data = i_value_in;
            end else begin : g_mid
                assign left_data = cell_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign right_data = cell_data[g];
            end else begin : g_body
                assign right_data = cell_data[g+1];
            end
            iq_cell #(
                .IDX   (g),
                .CNT_W (CntW),
                .LAST  (g == DEPTH - 1)
            ) u_cell (
                .i_clk      (i_clk),
                .i_act      (act),
                .i_pos      (cell_pos),
                .i_value    (i_value_in),
                .i_left     (left_data),
                .i_right    (right_data),
                .o_data     (cell_data[g]),
                .o_sel_data (cell_sel[g])
            );
        end
    endgenerate

    // Only the addressed cell drives a nonzero value, so an OR merges them.
    always_comb begin
        picked = '0;
        for (int k = 0; k < DEPTH; k++) begin
            picked = picked | cell_sel[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value  <= n_value;
            r_status <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value_out = r_value;
    assign o_status    = r_status;
    assign o_occupancy = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Full)
        else $error("queue count exceeds depth");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_count))
        else $error("queue count changed without a transfer");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && mode == MODE_PUSH && r_count == Full |=> r_status == ST_FULL
            && r_count == Full)
        else $error("push into a full queue was not flagged");

    a_step_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_count == $past(r_count) || r_count == $past(r_count) + 1'b1
            || r_count == $past(r_count) - 1'b1))
        else $error("queue count moved by more than one entry");

endmodule : indexed_queue_top

`default_nettype wire
